// File: hdl/radix_number_formatter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the formatter RTL
// ----------------------------------------------------------------------------
`ifndef RADIX_NUMBER_FORMATTER_TOP_MACROS_SVH
`define RADIX_NUMBER_FORMATTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RNF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rnf_pkg.sv
// ----------------------------------------------------------------------------
// rnf_pkg
// Types and constants of the radix number formatter.
// ----------------------------------------------------------------------------
package rnf_pkg;

    localparam int RADIX_W     = 7;
    localparam int CHAR_W      = 8;
    localparam int MAG_W       = 31;
    localparam int ALPHA_DEPTH = 64;
    localparam int ALPHA_AW    = 6;
    localparam int DIG_DEPTH   = 31;
    localparam int DIG_AW      = 5;
    localparam int DIGIT_W     = 6;
    localparam int DIV_CNT_W   = 5;
    localparam int TDATA_IN_W  = 48;

    localparam logic [RADIX_W-1:0] MIN_RADIX   = 7'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX   = 7'd64;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
    localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2D;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    // last step of the bit-serial divider
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_WAIT,
        S_SIGN,
        S_DIG_RD,
        S_ALPH_RD,
        S_PUT
    } state_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [MAG_W-1:0]   quot;
        logic [DIGIT_W-1:0] rem;
    } div_rsp_t;

endpackage

// File: hdl/radix_number_formatter_top.sv
// ----------------------------------------------------------------------------
// radix_number_formatter_top
// Formats a magnitude and sign flag as text in a configurable radix.
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one alphabet byte and returns nothing.
// A convert request (tuser 1) takes one request at a time: each digit is
// one pass of the bit-serial divider over the 31-bit magnitude, then each
// character goes through the digit buffer and alphabet memory reads, with
// a minus sign first for a negative nonzero number; a zero magnitude skips
// the divider. Both stores have no reset and no clearing pass; the radix is
// clamped to 2..64.
`include "radix_number_formatter_top_macros.svh"

module radix_number_formatter_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config: radix
    input  logic                             cfg_wr_en,
    input  logic [rnf_pkg::RADIX_W-1:0]      cfg_wr_data,
    // tdata: entry_index[5:0], entry_char[13:6], magnitude[44:14], negative[45]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rnf_pkg::TDATA_IN_W-1:0]   s_tdata,
    // tuser: func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: out_char[7:0]
    output logic [rnf_pkg::CHAR_W-1:0]       m_tdata,
    output logic                             m_tlast
);
    import rnf_pkg::*;

    state_t               state_reg, state_next;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RADIX_W-1:0]   eff_radix;

    logic [ALPHA_AW-1:0]  in_index;
    logic [CHAR_W-1:0]    in_char;
    logic [MAG_W-1:0]     in_mag;
    logic                 in_neg;
    logic                 s_req;

    logic                 neg_reg;
    logic                 zero_reg;
    logic [DIG_AW-1:0]    dig_cnt_reg;
    logic [DIG_AW-1:0]    dig_idx_reg;

    logic [CHAR_W-1:0]    alphabet_mem [ALPHA_DEPTH];
    logic [DIGIT_W-1:0]   digit_mem    [DIG_DEPTH];
    logic [DIGIT_W-1:0]   dig_rd_q;
    logic [CHAR_W-1:0]    alph_rd_q;
    logic [ALPHA_AW-1:0]  alph_addr;

    logic                 div_start;
    logic [MAG_W-1:0]     div_dividend;
    div_rsp_t             div_rsp;

    logic                 m_valid_reg;
    logic [CHAR_W-1:0]    m_data_reg;
    logic                 m_last_reg;
    logic                 slot_free;
    logic                 put_en;
    logic [CHAR_W-1:0]    put_char;
    logic                 put_last;

    assign in_index = s_tdata[5:0];
    assign in_char  = s_tdata[13:6];
    assign in_mag   = s_tdata[44:14];
    assign in_neg   = s_tdata[45];

    assign s_tready = (state_reg == S_IDLE);
    assign s_req    = s_tvalid && s_tready;

    always_comb begin
        priority if (radix_reg < MIN_RADIX) begin
            eff_radix = MIN_RADIX;
        end else if (radix_reg > MAX_RADIX) begin
            eff_radix = MAX_RADIX;
        end else begin
            eff_radix = radix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    rnf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_radix),
        .rsp      (div_rsp)
    );

    assign div_dividend = (state_reg == S_IDLE) ? in_mag : div_rsp.quot;
    assign slot_free    = !m_valid_reg || m_tready;

    // memory reads are always issued; the read data is registered
    assign alph_addr = zero_reg ? '0 : dig_rd_q;

    always_ff @(posedge aclk) begin
        if (s_req && s_tuser == FUNC_LOAD) begin
            alphabet_mem[in_index] <= in_char;
        end
        alph_rd_q <= alphabet_mem[alph_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DIV_WAIT && div_rsp.done) begin
            digit_mem[dig_cnt_reg] <= div_rsp.rem;
        end
        dig_rd_q <= digit_mem[dig_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        put_en     = 1'b0;
        put_char   = alph_rd_q;
        put_last   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_req && s_tuser == FUNC_CONVERT) begin
                    if (in_mag == '0) begin
                        state_next = S_ALPH_RD;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV_WAIT;
                    end
                end
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot != '0) begin
                        div_start = 1'b1;
                    end else begin
                        state_next = neg_reg ? S_SIGN : S_DIG_RD;
                    end
                end
            end
            S_SIGN: begin
                if (slot_free) begin
                    put_en     = 1'b1;
                    put_char   = MINUS_CHAR;
                    state_next = S_DIG_RD;
                end
            end
            S_DIG_RD: begin
                state_next = S_ALPH_RD;
            end
            S_ALPH_RD: begin
                state_next = S_PUT;
            end
            S_PUT: begin
                if (slot_free) begin
                    put_en     = 1'b1;
                    put_last   = zero_reg || dig_idx_reg == '0;
                    state_next = put_last ? S_IDLE : S_DIG_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_reg    <= 1'b0;
            dig_cnt_reg <= '0;
            dig_idx_reg <= '0;
        end else begin
            if (s_req && s_tuser == FUNC_CONVERT) begin
                zero_reg    <= (in_mag == '0);
                dig_cnt_reg <= '0;
                dig_idx_reg <= '0;
            end else if (state_reg == S_DIV_WAIT && div_rsp.done) begin
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
                dig_idx_reg <= dig_cnt_reg;
            end else if (state_reg == S_PUT && put_en && !put_last) begin
                dig_idx_reg <= dig_idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_req) begin
            neg_reg <= in_neg;
        end
    end

    // output register parts the result side from the formatter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (put_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (put_en) begin
            m_data_reg <= put_char;
            m_last_reg <= put_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `RNF_ASSERT_NOW(a_start_when_free, div_start, !div_rsp.busy,
        "divider started while busy")
    `RNF_ASSERT_NOW(a_done_in_wait, div_rsp.done, state_reg == S_DIV_WAIT,
        "divider result outside the wait state")
    `RNF_ASSERT_NOW(a_digit_written, state_reg == S_DIG_RD && !zero_reg,
        dig_idx_reg < dig_cnt_reg, "digit read beyond written entries")
    `RNF_ASSERT_NOW(a_put_needs_slot, put_en, slot_free,
        "output register overwritten while held")

endmodule

// File: hdl/rnf_div.sv
// ----------------------------------------------------------------------------
// rnf_div
// Bit-serial restoring divider: 31-bit dividend by a 7-bit radix, one
// quotient bit per cycle, remainder below the divisor.
// ----------------------------------------------------------------------------
`include "radix_number_formatter_top_macros.svh"

module rnf_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rnf_pkg::MAG_W-1:0]    dividend,
    input  logic [rnf_pkg::RADIX_W-1:0]  divisor,
    output rnf_pkg::div_rsp_t            rsp
);
    import rnf_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MAG_W-1:0]     q_reg;
    logic [DIGIT_W-1:0]   r_reg;
    logic [DIGIT_W-1:0]   r_next;
    logic [RADIX_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RADIX_W-1:0]   trial;
    logic [RADIX_W-1:0]   diff;
    logic                 ge;

    // shift the next dividend bit into the partial remainder
    assign trial  = {r_reg, q_reg[MAG_W-1]};
    assign ge     = trial >= dvs_reg;
    assign diff   = trial - dvs_reg;
    assign r_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[MAG_W-2:0], ge};
            r_reg   <= r_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

    `RNF_ASSERT_NOW(a_rem_below_divisor, done_reg, {1'b0, r_reg} < dvs_reg,
        "divider remainder not below divisor")
    `RNF_ASSERT_NEXT(a_done_ends_busy, done_reg, !busy_reg || $past(start),
        "divider busy after done without restart")
    `RNF_ASSERT_NEXT(a_done_single, done_reg, !done_reg,
        "divider done held for more than one cycle")

endmodule

// File: dv/rnf_text_checker.sv
// ----------------------------------------------------------------------------
// rnf_text_checker
// Watches the request, result and radix ports of the formatter, predicts the
// text that each convert request should produce and compares every
// character and its end-of-number flag against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnf_text_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rnf_pkg::RADIX_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // tdata: entry_index[5:0], entry_char[13:6], magnitude[44:14], negative[45]
    input  logic [rnf_pkg::TDATA_IN_W-1:0] s_tdata,
    // tuser: func
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: out_char[7:0]
    input  logic [rnf_pkg::CHAR_W-1:0]     m_tdata,
    input  logic                           m_tlast,
    output int                             err_count,
    output int                             chars_pending
);
    import rnf_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              tail;
    } text_char_t;

    logic [CHAR_W-1:0]  alphabet_copy [ALPHA_DEPTH];
    logic [RADIX_W-1:0] radix_copy;
    text_char_t         expected_text [$];
    int                 errors;

    initial begin
        foreach (alphabet_copy[i]) alphabet_copy[i] = '0;
        radix_copy    = RADIX_RESET;
        errors        = 0;
    end

    function automatic logic [RADIX_W-1:0] clamp_base(logic [RADIX_W-1:0] r);
        if (r < MIN_RADIX) return MIN_RADIX;
        if (r > MAX_RADIX) return MAX_RADIX;
        return r;
    endfunction

    task automatic queue_text(logic [MAG_W-1:0] mag, logic neg);
        logic [DIGIT_W-1:0] digits [DIG_DEPTH];
        logic [RADIX_W-1:0] base;
        logic [MAG_W-1:0]   rest;
        int                 ndig;
        text_char_t         c;
        base = clamp_base(radix_copy);
        rest = mag;
        ndig = 0;
        if (mag == 0) begin
            // zero: first alphabet entry only, sign dropped
            c.ch   = alphabet_copy[0];
            c.tail = 1'b1;
            expected_text.push_back(c);
            return;
        end
        while (rest != 0 && ndig < DIG_DEPTH) begin
            digits[ndig] = DIGIT_W'(rest % base);
            rest         = rest / base;
            ndig++;
        end
        if (neg) begin
            c.ch   = MINUS_CHAR;
            c.tail = 1'b0;
            expected_text.push_back(c);
        end
        for (int d = ndig - 1; d >= 0; d--) begin
            c.ch   = alphabet_copy[digits[d]];
            c.tail = (d == 0);
            expected_text.push_back(c);
        end
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (cfg_wr_en)
                radix_copy = cfg_wr_data;

            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected char: expected none, actual %02h last %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch) begin
                        $display("%0t: out_char mismatch: expected %02h, actual %02h",
                                 $time, want.ch, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.tail) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.tail, m_tlast);
                        errors++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_LOAD)
                    alphabet_copy[s_tdata[5:0]] = s_tdata[13:6];
                else
                    queue_text(s_tdata[44:14], s_tdata[45]);
            end
        end
        err_count     <= errors;
        chars_pending <= expected_text.size();
    end

endmodule

// File: dv/radix_number_formatter_top_tb.sv
// ----------------------------------------------------------------------------
// radix_number_formatter_top_tb
// Fills the alphabet, runs directed and random load and convert requests
// under several radix settings with random source gaps and sink stalls, and
// reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_number_formatter_top_tb;
    import rnf_pkg::*;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [RADIX_W-1:0]       cfg_wr_data = '0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [TDATA_IN_W-1:0]    s_tdata     = '0;
    logic                     s_tuser     = FUNC_LOAD;
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [CHAR_W-1:0]        m_tdata;
    logic                     m_tlast;
    logic                     calm        = 1'b0;
    int                       hold_cnt    = 0;
    int                       err_count;
    int                       chars_pending;

    always #10 aclk = ~aclk;

    radix_number_formatter_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    rnf_text_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .err_count     (err_count),
        .chars_pending (chars_pending)
    );

    // sink stalls in bursts of random length
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            hold_cnt <= $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(logic func, logic [ALPHA_AW-1:0] idx, logic [CHAR_W-1:0] ch,
                                logic [MAG_W-1:0] mag, logic neg);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, neg, mag, ch, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_entry(logic [ALPHA_AW-1:0] idx, logic [CHAR_W-1:0] ch);
        send_request(FUNC_LOAD, idx, ch, MAG_W'($urandom), 1'($urandom));
    endtask

    task automatic convert(logic [MAG_W-1:0] mag, logic neg);
        send_request(FUNC_CONVERT, ALPHA_AW'($urandom), CHAR_W'($urandom), mag, neg);
    endtask

    // stop sending and wait until every predicted char has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chars_pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_radix(logic [RADIX_W-1:0] r);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_request();
        int          w;
        logic [31:0] rnd;
        if ($urandom_range(0, 4) == 0) begin
            load_entry(ALPHA_AW'($urandom), CHAR_W'($urandom));
        end else begin
            w   = $urandom_range(0, 31);
            rnd = $urandom;
            // varied magnitude sizes so digit counts spread out
            convert(MAG_W'(rnd >> (32 - w)), 1'($urandom));
        end
    endtask

    initial begin
        logic [RADIX_W-1:0] r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every alphabet entry written before any convert reads it
        for (int i = 0; i < ALPHA_DEPTH; i++)
            load_entry(ALPHA_AW'(i), CHAR_W'($urandom));

        // directed, reset radix
        convert(31'd0, 1'b0);
        convert(31'd0, 1'b1);
        convert(31'h7FFF_FFFF, 1'b0);
        convert(31'h7FFF_FFFF, 1'b1);
        convert(31'd1, 1'b1);
        convert(31'd9, 1'b0);
        convert(31'd10, 1'b1);
        load_entry(6'd0, 8'h00);
        load_entry(6'd63, 8'hFF);
        convert(31'd0, 1'b1);
        set_radix(7'd64);
        convert(31'd63, 1'b0);
        convert(31'd64, 1'b1);
        convert(31'h7FFF_FFFF, 1'b1);
        set_radix(7'd2);
        convert(31'h7FFF_FFFF, 1'b1);
        convert(31'h4000_0000, 1'b0);
        convert(31'd1, 1'b0);
        set_radix(7'd0);
        convert(31'd5, 1'b1);
        set_radix(7'd1);
        convert(31'd6, 1'b0);
        set_radix(7'd127);
        convert(31'd4095, 1'b1);
        set_radix(7'd65);
        convert(31'h7FFF_FFFF, 1'b0);

        // random phases, each under its own radix
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: r = 7'd3;
                1: r = 7'd16;
                2: r = 7'd2;
                3: r = 7'd64;
                4: r = 7'd36;
                5: r = RADIX_W'($urandom_range(0, 127));
                6: r = 7'd127;
                default: r = 7'd8;
            endcase
            set_radix(r);
            if (p == 7)
                calm <= 1'b1;
            for (int k = 0; k < 47; k++)
                random_request();
        end

        drain();
        repeat (40) @(posedge aclk);
        if (err_count == 0 && chars_pending == 0)
            $display("radix_number_formatter_top_tb: done, clean");
        else
            $display("radix_number_formatter_top_tb: done, errors");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("radix_number_formatter_top_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/rnf_pkg.sv
hdl/rnf_div.sv
hdl/radix_number_formatter_top.sv
dv/rnf_text_checker.sv
dv/radix_number_formatter_top_tb.sv
